[design/vrt_pkg.sv]
`timescale 1ns / 1ps

package vrt_pkg;

    localparam int POS_W  = 32;   // ray start, signed fixed point
    localparam int DIR_W  = 18;   // direction component, signed fixed point
    localparam int CNT_W  = 7;    // voxel count
    localparam int VOX_W  = 17;   // voxel coordinate, wraps
    localparam int TIME_W = 32;   // crossing time, unsigned fixed point
    localparam int NUM_AX = 3;
    localparam int AX_W   = 2;    // axis index

    localparam logic [TIME_W-1:0] TIME_ONES = '1;

    // op index: axis in the upper bits, time/delta in the low bit
    localparam logic [2:0] OP_LAST = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_ISSUE,
        S_DIV_WAIT,
        S_WALK
    } t_state;

    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] quot;
    } t_div_rsp;

endpackage

[design/vrt_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, result saturated to 32 bits.
module vrt_div #(
    parameter int NUM_W = 33
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [NUM_W-1:0]            i_num,
    input  logic [vrt_pkg::DIR_W-1:0]   i_den,
    output vrt_pkg::t_div_rsp           o_rsp
);
    import vrt_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CW-1:0]     r_cnt,  n_cnt;
    logic [NUM_W-1:0]  r_num,  n_num;
    logic [DIR_W:0]    r_rem,  n_rem;
    logic [DIR_W-1:0]  r_den,  n_den;

    logic [DIR_W:0]    w_trial;
    logic              w_ge;

    assign w_trial = {r_rem[DIR_W-1:0], r_num[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(NUM_W);
            n_num  = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = w_ge ? (w_trial - {1'b0, r_den}) : w_trial;
            n_num = {r_num[NUM_W-2:0], w_ge};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = (|r_num[NUM_W-1:TIME_W]) ? TIME_ONES : r_num[TIME_W-1:0];

    // a new division is only issued to an idle divider
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    // done follows the final step
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while busy");

    // remainder stays below the divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_den != '0) |-> (r_rem < {1'b0, r_den}))
        else $error("divider remainder out of range");

endmodule

[design/voxel_ray_traversal.sv]
`timescale 1ns / 1ps

// 3-D voxel walk of a ray. An item (start point, direction, voxel count) is
// taken when start is high and busy is low; busy then stays high until the
// last voxel has been issued. Setup runs six divisions (first crossing time
// and time per voxel for each axis) through one shared restoring divider that
// yields one quotient bit per cycle; an axis with zero direction skips its two
// divisions. The walk then issues one voxel per cycle. Each voxel appears on
// o_voxel_x/y/z for exactly one cycle with o_valid high, o_last marking the
// final one; the receiver cannot stall, so every voxel must be taken as it
// comes. A count of 0 or 1 gives the start voxel only; a count above
// MAX_VOXELS is clipped to MAX_VOXELS.
module voxel_ray_traversal #(
    parameter int MAX_VOXELS = 64,   // 1..64
    parameter int FRAC_BITS  = 16    // 8..24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [vrt_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [vrt_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [vrt_pkg::POS_W-1:0]   i_pos_z,
    input  logic signed [vrt_pkg::DIR_W-1:0]   i_dir_x,
    input  logic signed [vrt_pkg::DIR_W-1:0]   i_dir_y,
    input  logic signed [vrt_pkg::DIR_W-1:0]   i_dir_z,
    input  logic [vrt_pkg::CNT_W-1:0]          i_voxel_count,
    output logic                               o_valid,
    output logic signed [vrt_pkg::VOX_W-1:0]   o_voxel_x,
    output logic signed [vrt_pkg::VOX_W-1:0]   o_voxel_y,
    output logic signed [vrt_pkg::VOX_W-1:0]   o_voxel_z,
    output logic                               o_last
);
    import vrt_pkg::*;

    // dividend width: (dist << F) needs 2F+1 bits; never less than 33 so the
    // saturation check always has an upper slice to look at
    localparam int QW     = (2 * FRAC_BITS + 1 > TIME_W + 1) ?
                            2 * FRAC_BITS + 1 : TIME_W + 1;
    localparam int DIST_W = FRAC_BITS + 1;
    localparam logic [DIST_W-1:0] ONE_F = DIST_W'(1) << FRAC_BITS;
    localparam logic [QW-1:0] DELTA_NUM = QW'(1) << (2 * FRAC_BITS);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VOXELS);

    t_state r_state, n_state;

    // per-axis walk state
    logic [VOX_W-1:0]  r_cur   [NUM_AX];
    logic [VOX_W-1:0]  n_cur   [NUM_AX];
    logic [TIME_W-1:0] r_time  [NUM_AX];
    logic [TIME_W-1:0] n_time  [NUM_AX];
    logic [TIME_W-1:0] r_delta [NUM_AX];
    logic [TIME_W-1:0] n_delta [NUM_AX];
    logic              r_neg   [NUM_AX];
    logic              n_neg   [NUM_AX];
    // setup operands
    logic [DIST_W-1:0] r_dist  [NUM_AX];
    logic [DIST_W-1:0] n_dist  [NUM_AX];
    logic [DIR_W-1:0]  r_mag   [NUM_AX];
    logic [DIR_W-1:0]  n_mag   [NUM_AX];

    logic [CNT_W-1:0]  r_steps, n_steps;
    logic [2:0]        r_op,    n_op;

    // output stage
    logic              r_valid, n_valid;
    logic              r_last,  n_last;
    logic [VOX_W-1:0]  r_out   [NUM_AX];
    logic [VOX_W-1:0]  n_out   [NUM_AX];

    logic signed [POS_W-1:0] w_pos [NUM_AX];
    logic signed [DIR_W-1:0] w_dir [NUM_AX];
    logic [CNT_W-1:0]  w_cnt;
    logic [AX_W-1:0]   w_axis;
    logic              w_kind;      // 0: first crossing time, 1: delta
    logic [AX_W-1:0]   w_pick;
    logic [TIME_W:0]   w_sum;
    logic              w_accept;

    logic              w_div_start;
    logic [QW-1:0]     w_div_num;
    t_div_rsp          w_div_rsp;

    assign w_pos[0] = i_pos_x;
    assign w_pos[1] = i_pos_y;
    assign w_pos[2] = i_pos_z;
    assign w_dir[0] = i_dir_x;
    assign w_dir[1] = i_dir_y;
    assign w_dir[2] = i_dir_z;

    assign w_accept = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);

    assign w_axis = r_op[2:1];
    assign w_kind = r_op[0];

    // clip the count to 1..MAX_VOXELS
    always_comb begin
        if (i_voxel_count == '0) begin
            w_cnt = CNT_W'(1);
        end else if (i_voxel_count > MAX_CNT) begin
            w_cnt = MAX_CNT;
        end else begin
            w_cnt = i_voxel_count;
        end
    end

    assign w_div_num = w_kind ? DELTA_NUM : (QW'(r_dist[w_axis]) << FRAC_BITS);

    // strictly smallest time wins; ties go to z, then y over x
    always_comb begin
        if (r_time[0] < r_time[1]) begin
            w_pick = (r_time[0] < r_time[2]) ? AX_W'(0) : AX_W'(2);
        end else begin
            w_pick = (r_time[1] < r_time[2]) ? AX_W'(1) : AX_W'(2);
        end
    end

    assign w_sum = {1'b0, r_time[w_pick]} + {1'b0, r_delta[w_pick]};

    vrt_div #(
        .NUM_W (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_mag[w_axis]),
        .o_rsp   (w_div_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_time      = r_time;
        n_delta     = r_delta;
        n_neg       = r_neg;
        n_dist      = r_dist;
        n_mag       = r_mag;
        n_steps     = r_steps;
        n_op        = r_op;
        n_valid     = 1'b0;
        n_last      = r_last;
        n_out       = r_out;
        w_div_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    for (int a = 0; a < NUM_AX; a++) begin
                        n_cur[a]  = VOX_W'(w_pos[a] >>> FRAC_BITS);
                        n_neg[a]  = w_dir[a][DIR_W-1];
                        n_mag[a]  = w_dir[a][DIR_W-1] ? DIR_W'(-w_dir[a]) : w_dir[a];
                        n_dist[a] = w_dir[a][DIR_W-1] ?
                                    {1'b0, w_pos[a][FRAC_BITS-1:0]} :
                                    ONE_F - {1'b0, w_pos[a][FRAC_BITS-1:0]};
                    end
                    n_steps = w_cnt - CNT_W'(1);
                    n_op    = '0;
                    n_state = S_DIV_ISSUE;
                end
            end
            S_DIV_ISSUE: begin
                if (r_mag[w_axis] == '0) begin
                    // zero direction: never crosses
                    if (w_kind) begin
                        n_delta[w_axis] = TIME_ONES;
                    end else begin
                        n_time[w_axis] = TIME_ONES;
                    end
                    n_op    = r_op + 3'd1;
                    n_state = (r_op == OP_LAST) ? S_WALK : S_DIV_ISSUE;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                if (w_div_rsp.done) begin
                    if (w_kind) begin
                        n_delta[w_axis] = w_div_rsp.quot;
                    end else begin
                        n_time[w_axis] = w_div_rsp.quot;
                    end
                    n_op    = r_op + 3'd1;
                    n_state = (r_op == OP_LAST) ? S_WALK : S_DIV_ISSUE;
                end
            end
            S_WALK: begin
                // issue the current voxel, then step
                n_valid = 1'b1;
                n_out   = r_cur;
                n_last  = (r_steps == '0);
                if (r_steps == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_cur[w_pick]  = r_neg[w_pick] ? r_cur[w_pick] - VOX_W'(1) :
                                                     r_cur[w_pick] + VOX_W'(1);
                    n_time[w_pick] = w_sum[TIME_W] ? TIME_ONES : w_sum[TIME_W-1:0];
                    n_steps        = r_steps - CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_steps <= '0;
            r_op    <= '0;
            for (int a = 0; a < NUM_AX; a++) begin
                r_cur[a]   <= '0;
                r_time[a]  <= '0;
                r_delta[a] <= '0;
                r_neg[a]   <= 1'b0;
            end
        end else begin
            r_valid <= n_valid;
            r_steps <= n_steps;
            r_op    <= n_op;
            r_cur   <= n_cur;
            r_time  <= n_time;
            r_delta <= n_delta;
            r_neg   <= n_neg;
        end
        r_dist <= n_dist;
        r_mag  <= n_mag;
        r_last <= n_last;
        r_out  <= n_out;
    end

    assign o_valid   = r_valid;
    assign o_last    = r_last;
    assign o_voxel_x = r_out[0];
    assign o_voxel_y = r_out[1];
    assign o_voxel_z = r_out[2];

    // voxels only come out of the walk
    a_valid_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_WALK))
        else $error("voxel issued outside the walk");

    // an accepted item raises busy through the state register
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted item did not raise busy");

    // the final voxel hands control back to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (r_state == S_IDLE))
        else $error("last voxel issued but walk still running");

    // remaining count never exceeds the clip limit
    a_steps_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_steps < MAX_CNT))
        else $error("voxel count beyond limit");

    // the divider only runs during setup
    a_div_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV_WAIT))
        else $error("divider result outside setup");

endmodule
